// ===== rtl/servo_instruction_packet_framer_defines.svh =====
// Assertion macros shared by the framer RTL.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef SERVO_INSTRUCTION_PACKET_FRAMER_DEFINES_SVH
`define SERVO_INSTRUCTION_PACKET_FRAMER_DEFINES_SVH

// Condition that must hold at every clock edge.
`define SIPF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Cause in one cycle, effect in the following cycle.
`define SIPF_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |=> (effect)) else $error(msg);

`endif

// ===== rtl/sipf_pkg.sv =====
package sipf_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    REQ_PING    = 3'd0,
    REQ_READ8   = 3'd1,
    REQ_READ16  = 3'd2,
    REQ_WRITE8  = 3'd3,
    REQ_WRITE16 = 3'd4,
    REQ_POS     = 3'd5,
    REQ_WHEEL   = 3'd6
  } sipf_req_e;

  // Reply expected after a packet
  typedef enum logic [1:0] {
    ANS_NONE  = 2'd0,
    ANS_CHECK = 2'd1,
    ANS_STORE = 2'd2
  } sipf_ans_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } sipf_state_e;

  // Protocol constants
  localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
  localparam logic [7:0]  BROADCAST_ID   = 8'hFE;
  localparam logic [7:0]  INSTR_PING     = 8'h01;
  localparam logic [7:0]  INSTR_READ     = 8'h02;
  localparam logic [7:0]  INSTR_WRITE    = 8'h03;
  localparam logic [7:0]  REG_MODE       = 8'h08;
  localparam logic [7:0]  REG_GOAL_POS   = 8'h1E;
  localparam logic [7:0]  REG_GOAL_SPEED = 8'h20;
  localparam logic [15:0] MODE_DEFAULT   = 16'h03FF;
  localparam logic [15:0] MODE_WHEEL     = 16'h0000;
  localparam logic [7:0]  READ8_LEN      = 8'h01;
  localparam logic [7:0]  READ16_LEN     = 8'h02;

  // Byte positions inside a packet
  localparam logic [3:0] POS_SYNC1  = 4'd1;
  localparam logic [3:0] POS_ID     = 4'd2;
  localparam logic [3:0] POS_LEN    = 4'd3;
  localparam logic [3:0] POS_INSTR  = 4'd4;
  localparam logic [3:0] POS_PARAM0 = 4'd5;
  localparam logic [3:0] POS_PARAM1 = 4'd6;
  localparam logic [3:0] POS_PARAM2 = 4'd7;

  // One result byte with its sideband
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
    sipf_ans_e  answer_kind;
    logic       last;
  } sipf_item_t;

  // Control of the shared checksum adder
  typedef struct packed {
    logic       clr;
    logic       add;
    logic [7:0] data;
  } sipf_csum_ctl_t;

endpackage

// ===== rtl/sipf_csum.sv =====
module sipf_csum (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sipf_pkg::sipf_csum_ctl_t ctl_i,
  output logic [7:0]               sum_o
);

  logic [7:0] sum_q, sum_d;

  // Running 8-bit sum, one byte per cycle while add is set
  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clr) begin
      sum_d = '0;
    end else if (ctl_i.add) begin
      sum_d = sum_q + ctl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/sipf_seq.sv =====
module sipf_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               req_i,
  input  logic [7:0]               id_i,
  input  logic [7:0]               addr_i,
  input  logic [15:0]              val_i,
  input  logic                     out_free_i,
  input  logic [7:0]               sum_i,
  output sipf_pkg::sipf_item_t     item_o,
  output logic                     item_valid_o,
  output sipf_pkg::sipf_csum_ctl_t csum_o
);

  sipf_pkg::sipf_state_e state_q, state_d;
  sipf_pkg::sipf_req_e   req_q, req_d;
  logic [7:0]            id_q, id_d;
  logic [7:0]            addr_q, addr_d;
  logic [15:0]           val_q, val_d;
  logic [3:0]            pos_q, pos_d;
  logic                  pkt2_q, pkt2_d;

  logic       accept, cmd_ok, step, is_csum, pkt_done, cmd_done;
  logic       dbl;
  logic [1:0] nparams;
  logic [3:0] csum_pos;
  logic [7:0] instr, pkt_len, p0, p1, p2, cur_byte;
  logic [15:0] data16;

  // Handshake and packet shape
  assign accept   = in_valid_i && (state_q == sipf_pkg::ST_IDLE);
  assign cmd_ok   = (req_i <= sipf_pkg::REQ_WHEEL);
  assign step     = (state_q == sipf_pkg::ST_SEND) && out_free_i;
  assign dbl      = (req_q == sipf_pkg::REQ_POS) || (req_q == sipf_pkg::REQ_WHEEL);
  assign csum_pos = sipf_pkg::POS_PARAM0 + {2'b00, nparams};
  assign pkt_len  = {6'd0, nparams} + 8'd2;
  assign is_csum  = (pos_q == csum_pos);
  assign pkt_done = step && is_csum;
  assign cmd_done = pkt_done && (!dbl || pkt2_q);

  // Instruction, parameter count and parameters of the current packet
  always_comb begin
    instr  = sipf_pkg::INSTR_WRITE;
    nparams = 2'd3;
    data16 = val_q;
    p0     = addr_q;
    unique case (req_q)
      sipf_pkg::REQ_PING: begin
        instr   = sipf_pkg::INSTR_PING;
        nparams = 2'd0;
      end
      sipf_pkg::REQ_READ8, sipf_pkg::REQ_READ16: begin
        instr   = sipf_pkg::INSTR_READ;
        nparams = 2'd2;
      end
      sipf_pkg::REQ_WRITE8: begin
        nparams = 2'd2;
      end
      sipf_pkg::REQ_WRITE16: begin
        nparams = 2'd3;
      end
      sipf_pkg::REQ_POS: begin
        p0     = pkt2_q ? sipf_pkg::REG_GOAL_POS : sipf_pkg::REG_MODE;
        data16 = pkt2_q ? val_q : sipf_pkg::MODE_DEFAULT;
      end
      sipf_pkg::REQ_WHEEL: begin
        p0     = pkt2_q ? sipf_pkg::REG_GOAL_SPEED : sipf_pkg::REG_MODE;
        data16 = pkt2_q ? val_q : sipf_pkg::MODE_WHEEL;
      end
      default: begin
        instr = sipf_pkg::INSTR_WRITE;
      end
    endcase
    if (req_q == sipf_pkg::REQ_READ8) begin
      p1 = sipf_pkg::READ8_LEN;
    end else if (req_q == sipf_pkg::REQ_READ16) begin
      p1 = sipf_pkg::READ16_LEN;
    end else begin
      p1 = data16[7:0];
    end
    p2 = data16[15:8];
  end

  // Byte selection by position
  always_comb begin
    case (pos_q)
      sipf_pkg::POS_ID:     cur_byte = id_q;
      sipf_pkg::POS_LEN:    cur_byte = pkt_len;
      sipf_pkg::POS_INSTR:  cur_byte = instr;
      sipf_pkg::POS_PARAM0: cur_byte = p0;
      sipf_pkg::POS_PARAM1: cur_byte = p1;
      sipf_pkg::POS_PARAM2: cur_byte = p2;
      default:              cur_byte = sipf_pkg::SYNC_BYTE;
    endcase
    if (is_csum) begin
      cur_byte = ~sum_i;
    end
  end

  // Result item
  always_comb begin
    item_o.tx_byte     = cur_byte;
    item_o.packet_end  = is_csum;
    item_o.answer_kind = sipf_pkg::ANS_NONE;
    item_o.last        = is_csum && (!dbl || pkt2_q);
    if (is_csum && (id_q != sipf_pkg::BROADCAST_ID)) begin
      if (instr == sipf_pkg::INSTR_WRITE) begin
        item_o.answer_kind = sipf_pkg::ANS_CHECK;
      end else begin
        item_o.answer_kind = sipf_pkg::ANS_STORE;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sipf_pkg::ST_IDLE: begin
        if (accept && cmd_ok) begin
          state_d = sipf_pkg::ST_SEND;
        end
      end
      sipf_pkg::ST_SEND: begin
        if (cmd_done) begin
          state_d = sipf_pkg::ST_IDLE;
        end
      end
      default: state_d = sipf_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and checksum adder control
  always_comb begin
    in_ready_o   = 1'b0;
    item_valid_o = 1'b0;
    csum_o.clr   = 1'b0;
    csum_o.add   = 1'b0;
    csum_o.data  = cur_byte;
    unique case (state_q)
      sipf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      sipf_pkg::ST_SEND: begin
        item_valid_o = out_free_i;
        csum_o.clr   = out_free_i && (pos_q <= sipf_pkg::POS_SYNC1);
        csum_o.add   = out_free_i && (pos_q >= sipf_pkg::POS_ID) && !is_csum;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // Command capture and position counter
  always_comb begin
    req_d  = req_q;
    id_d   = id_q;
    addr_d = addr_q;
    val_d  = val_q;
    pos_d  = pos_q;
    pkt2_d = pkt2_q;
    if (accept) begin
      req_d  = sipf_pkg::sipf_req_e'(req_i);
      id_d   = id_i;
      addr_d = addr_i;
      val_d  = val_i;
      pos_d  = '0;
      pkt2_d = 1'b0;
    end else if (step) begin
      if (pkt_done) begin
        pos_d  = '0;
        pkt2_d = 1'b1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sipf_pkg::ST_IDLE;
      pos_q   <= '0;
      pkt2_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      pkt2_q  <= pkt2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    id_q   <= id_d;
    addr_q <= addr_d;
    val_q  <= val_d;
  end

endmodule

// ===== rtl/servo_instruction_packet_framer.sv =====
// Servo instruction packet framer.
// Input stream: one command per transaction; tuser carries the command
// code, tdata the servo id, the register address and the 16-bit value.
// Output stream: one serial byte per transaction in tdata, tlast on the
// final byte of the command, tuser flags the checksum byte of each packet
// and the reply class expected for it.
// The first byte is offered once the sequencer has entered its send state
// and loaded it into the output register, then one byte per cycle while the
// receiver keeps tready high. A command is 6 bytes (ping), 8 (reads,
// write8), 9 (write16) or 18 (set position, wheel speed, two packets); the
// next command is taken in the cycle after the final byte is loaded. The
// byte sequencer and its single shared checksum adder set the byte rate.
// Command code 7 is taken and produces no bytes.
// A stalled receiver holds the current byte in the output register and the
// sequencer waits; nothing is dropped. Reset returns the sequencer to idle
// and empties the output register.
`include "servo_instruction_packet_framer_defines.svh"

module servo_instruction_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // servo_id[7:0], reg_addr[15:8], value[31:16]
  input  logic [2:0]  s_axis_tuser_i,   // req_type[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // tx_byte[7:0]
  output logic [2:0]  m_axis_tuser_o,   // packet_end[0], answer_kind[2:1]
  output logic        m_axis_tlast_o
);

  sipf_pkg::sipf_item_t     item, out_item_q, out_item_d;
  sipf_pkg::sipf_csum_ctl_t csum_ctl;
  logic                     item_valid, out_free;
  logic                     out_vld_q, out_vld_d;
  logic [7:0]               sum;

  assign out_free = !out_vld_q || m_axis_tready_i;

  sipf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .req_i        (s_axis_tuser_i),
    .id_i         (s_axis_tdata_i[7:0]),
    .addr_i       (s_axis_tdata_i[15:8]),
    .val_i        (s_axis_tdata_i[31:16]),
    .out_free_i   (out_free),
    .sum_i        (sum),
    .item_o       (item),
    .item_valid_o (item_valid),
    .csum_o       (csum_ctl)
  );

  sipf_csum u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (csum_ctl),
    .sum_o  (sum)
  );

  // Output register
  always_comb begin
    out_vld_d  = out_vld_q;
    out_item_d = out_item_q;
    if (item_valid) begin
      out_vld_d  = 1'b1;
      out_item_d = item;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_item_q.tx_byte;
  assign m_axis_tuser_o  = {out_item_q.answer_kind, out_item_q.packet_end};
  assign m_axis_tlast_o  = out_item_q.last;

  // Checks
  `SIPF_ASSERT_ALWAYS(a_last_ends_packet, !(m_axis_tvalid_o && m_axis_tlast_o) || m_axis_tuser_o[0], "final byte is not a checksum byte")
  `SIPF_ASSERT_ALWAYS(a_kind_only_at_end, !(m_axis_tvalid_o && !m_axis_tuser_o[0]) || (m_axis_tuser_o[2:1] == sipf_pkg::ANS_NONE), "reply class outside checksum byte")
  `SIPF_ASSERT_NEXT(a_busy_after_cmd, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i <= sipf_pkg::REQ_WHEEL), !s_axis_tready_o, "ready while a command is framed")

endmodule
